// ----- hw/rtl/lups_pkg.sv -----
// ----------------------------------------------------------------------------
// lups_pkg
// Shared types, codes and Q32.32 helpers of the pivoting LU solver.
// ----------------------------------------------------------------------------
package lups_pkg;

  localparam int MAX_SIZE_DEF = 16;
  localparam int MS_W         = 5;
  localparam int MS_RESET     = 16;

  localparam logic signed [63:0] Q_ONE   = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] Q_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_MIN   = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] Q_LSB   = 64'sh0000_0000_0000_0001;

  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_SOLVE  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [3:0]         row;
    logic [3:0]         column;
    logic signed [63:0] value;
  } in_req_t;

  typedef struct packed {
    logic [3:0]         element_index;
    logic signed [63:0] solution_value;
    logic               status;
    logic               last;
  } out_res_t;

  function automatic logic [63:0] q_mag(input logic signed [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic signed [63:0] from_mag(input logic neg, input logic [63:0] mag,
                                                  input logic ovf);
    logic signed [63:0] r;
    if (neg) begin
      if (ovf || mag[63]) r = Q_MIN;
      else r = 64'd0 - mag;
    end else begin
      if (ovf || mag[63]) r = Q_MAX;
      else r = mag;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] q_abs(input logic signed [63:0] v);
    return from_mag(1'b0, q_mag(v), 1'b0);
  endfunction

  function automatic logic signed [63:0] q_sub(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic [63:0] r;
    logic signed [63:0] res;
    r = a - b;
    if ((a[63] != b[63]) && (r[63] != a[63])) res = a[63] ? Q_MIN : Q_MAX;
    else res = r;
    return res;
  endfunction

endpackage

// ----- hw/rtl/lups_ram.sv -----
// ----------------------------------------------------------------------------
// lups_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lups_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/lups_mul.sv -----
// ----------------------------------------------------------------------------
// lups_mul
// Saturating Q32.32 multiplier, four 32x32 partial products over cycles.
// ----------------------------------------------------------------------------
module lups_mul
  import lups_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic               done,
  output logic signed [63:0] p
);

  logic [63:0]        xm_r, ym_r, pp_r;
  logic               neg_r, busy_r, done_r;
  logic [2:0]         cnt_r;
  logic [127:0]       acc_r;
  logic signed [63:0] p_r;
  logic [1:0]         am;
  logic [31:0]        xs, ys;
  logic [127:0]       addend;
  logic [63:0]        q0, q1;
  logic               rnd, ovf;

  always_comb begin
    xs = cnt_r[1] ? xm_r[63:32] : xm_r[31:0];
    ys = cnt_r[0] ? ym_r[63:32] : ym_r[31:0];
    am = 2'(cnt_r - 3'd1);
    case (am)
      2'd0:    addend = {64'd0, pp_r};
      2'd3:    addend = {pp_r, 64'd0};
      default: addend = {32'd0, pp_r, 32'd0};
    endcase
    q0  = acc_r[95:32];
    rnd = neg_r && (acc_r[31:0] != 32'd0);
    q1  = q0 + {63'd0, rnd};
    ovf = (acc_r[127:96] != 32'd0) || (rnd && (q1 == 64'd0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd0;
      end else if (busy_r) begin
        if (cnt_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xm_r  <= q_mag(a);
      ym_r  <= q_mag(b);
      neg_r <= a[63] ^ b[63];
      acc_r <= 128'd0;
    end else if (busy_r) begin
      if (cnt_r < 3'd4) begin
        pp_r <= {32'd0, xs} * {32'd0, ys};
      end
      if ((cnt_r >= 3'd1) && (cnt_r <= 3'd4)) begin
        acc_r <= acc_r + addend;
      end
      if (cnt_r == 3'd5) begin
        p_r <= from_mag(neg_r, q1, ovf);
      end
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

// ----- hw/rtl/lups_div.sv -----
// ----------------------------------------------------------------------------
// lups_div
// Saturating Q32.32 divider, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lups_div
  import lups_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic               done,
  output logic signed [63:0] q
);

  logic [95:0]        dvd_r;
  logic [63:0]        ub_r, rem_r, quo_r;
  logic               neg_r, ovf_r, busy_r, fin_r, done_r;
  logic [6:0]         cnt_r;
  logic signed [63:0] q_r;
  logic [63:0]        r2, rem_nxt;
  logic               ge;

  always_comb begin
    r2      = {rem_r[62:0], dvd_r[95]};
    ge      = r2 >= ub_r;
    rem_nxt = ge ? (r2 - ub_r) : r2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      fin_r  <= 1'b0;
      if (start) begin
        if (q_mag(b) == 64'd0) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        if (cnt_r == 7'd0) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {q_mag(a), 32'd0};
      ub_r  <= q_mag(b);
      neg_r <= a[63] ^ b[63];
      rem_r <= 64'd0;
      quo_r <= 64'd0;
      ovf_r <= 1'b0;
      cnt_r <= 7'd95;
      q_r   <= a[63] ? Q_MIN : Q_MAX;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[94:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[62:0], ge};
      ovf_r <= ovf_r | quo_r[63];
      cnt_r <= cnt_r - 7'd1;
    end else if (fin_r) begin
      q_r <= from_mag(neg_r, quo_r, ovf_r);
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

// ----- hw/rtl/lu_pivot_linear_solver.sv -----
// ----------------------------------------------------------------------------
// lu_pivot_linear_solver
// Dense linear solver in Q32.32: Crout LU with scaled partial pivoting.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_ready with an in_req_t payload: load a
// matrix entry, load a right-hand-side entry, or solve. Loads are taken one
// per cycle. A solve holds in_ready low until its results are all taken.
// Results leave on out_valid/out_ready as out_res_t: one per solution
// element in index order, last set on the final one, or a single result
// with status set if a row of the n by n matrix is all zeros. After a
// successful solve the right-hand-side store holds the solution.
// cfg_we/cfg_wdata set the order n (0 acts as 1, above MAX_SIZE as MAX_SIZE).
// Each multiply-subtract runs on the shared multiplier, plus its memory
// reads. A full solve makes 3n-1 divisions, all in the serial divider,
// and each result is read from the store, loaded and held until taken.
// A stalled receiver holds the result register and the sequencer.
// Reset (rst_n low at a clock edge) returns to idle with n = 16; the
// stores are not cleared and must be loaded before a solve.
// ----------------------------------------------------------------------------
module lu_pivot_linear_solver
  import lups_pkg::*;
#(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_req_t         in_req,
  output logic            out_valid,
  input  logic            out_ready,
  output out_res_t        out_res,
  input  logic            cfg_we,
  input  logic [MS_W-1:0] cfg_wdata
);

  localparam int DEPTH2 = MAX_SIZE * MAX_SIZE;
  localparam int AW     = $clog2(DEPTH2);
  localparam int VW     = $clog2(MAX_SIZE);
  localparam int CW     = $clog2(MAX_SIZE + 1);

  typedef enum logic [44:0] {
    S_IDLE    = 45'b1 << 0,  S_SC_RD   = 45'b1 << 1,  S_SC_WR   = 45'b1 << 2,
    S_SC_CHK  = 45'b1 << 3,  S_SC_DIV  = 45'b1 << 4,  S_CR_ST   = 45'b1 << 5,
    S_CR_SUM  = 45'b1 << 6,  S_CR_RA   = 45'b1 << 7,  S_CR_RB   = 45'b1 << 8,
    S_CR_MUL  = 45'b1 << 9,  S_CR_MW   = 45'b1 << 10, S_CR_WR   = 45'b1 << 11,
    S_CR_SC   = 45'b1 << 12, S_CR_SW   = 45'b1 << 13, S_PV_CHK  = 45'b1 << 14,
    S_PV_SC   = 45'b1 << 15, S_SW_RA   = 45'b1 << 16, S_SW_RB   = 45'b1 << 17,
    S_SW_W1   = 45'b1 << 18, S_SW_W2   = 45'b1 << 19, S_ZP_RD   = 45'b1 << 20,
    S_ZP_CHK  = 45'b1 << 21, S_ZP_DIV  = 45'b1 << 22, S_CS_RD   = 45'b1 << 23,
    S_CS_MUL  = 45'b1 << 24, S_CS_MW   = 45'b1 << 25, S_FW_PV   = 45'b1 << 26,
    S_FW_IP   = 45'b1 << 27, S_FW_RI   = 45'b1 << 28, S_FW_SW   = 45'b1 << 29,
    S_FW_RA   = 45'b1 << 30, S_FW_MUL  = 45'b1 << 31, S_FW_MW   = 45'b1 << 32,
    S_FW_WR   = 45'b1 << 33, S_BK_RD   = 45'b1 << 34, S_BK_SUM  = 45'b1 << 35,
    S_BK_RA   = 45'b1 << 36, S_BK_MUL  = 45'b1 << 37, S_BK_MW   = 45'b1 << 38,
    S_BK_DR   = 45'b1 << 39, S_BK_DIV  = 45'b1 << 40, S_BK_DW   = 45'b1 << 41,
    S_EM_RD   = 45'b1 << 42, S_EM_LD   = 45'b1 << 43, S_EM_WT   = 45'b1 << 44
  } state_t;

  state_t             state_r, state_nxt;
  logic [MS_W-1:0]    ms_r;
  logic [CW-1:0]      n_r, n_nxt, i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [CW-1:0]      first_r, first_nxt, ip_r, ip_nxt, imax_r, imax_nxt;
  logic               started_r, started_nxt, out_valid_r, out_valid_nxt;
  logic signed [63:0] sum_r, sum_nxt, a_r, a_nxt, big_r, big_nxt;
  logic signed [63:0] tmp_r, tmp_nxt, dum_r, dum_nxt;
  out_res_t           out_r, out_nxt;

  logic [CW-1:0]      n_clamp, kl, ipv;
  logic               last_i, last_j;
  logic signed [63:0] t_abs, pv;

  logic               coef_we, lu_we, rhs_we, sc_we, piv_we;
  logic [AW-1:0]      coef_waddr, coef_raddr, lu_waddr, lu_raddr;
  logic [63:0]        coef_rdata, lu_wdata, lu_rdata;
  logic [VW-1:0]      rhs_waddr, rhs_raddr, sc_waddr, sc_raddr, piv_waddr, piv_raddr;
  logic [63:0]        rhs_wdata, rhs_rdata, sc_wdata, sc_rdata;
  logic [VW-1:0]      piv_wdata, piv_rdata;

  logic               mul_start, mul_done, div_start, div_done;
  logic signed [63:0] mul_a, mul_b, mul_p, div_a, div_b, div_q;

  function automatic logic [AW-1:0] ea(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return AW'(32'(r) * MAX_SIZE + 32'(c));
  endfunction

  lups_ram #(.WIDTH(64), .DEPTH(DEPTH2)) u_coef_ram (
    .clk(clk), .we(coef_we), .waddr(coef_waddr), .wdata(in_req.value),
    .raddr(coef_raddr), .rdata(coef_rdata));
  lups_ram #(.WIDTH(64), .DEPTH(DEPTH2)) u_lu_ram (
    .clk(clk), .we(lu_we), .waddr(lu_waddr), .wdata(lu_wdata),
    .raddr(lu_raddr), .rdata(lu_rdata));
  lups_ram #(.WIDTH(64), .DEPTH(MAX_SIZE)) u_rhs_ram (
    .clk(clk), .we(rhs_we), .waddr(rhs_waddr), .wdata(rhs_wdata),
    .raddr(rhs_raddr), .rdata(rhs_rdata));
  lups_ram #(.WIDTH(64), .DEPTH(MAX_SIZE)) u_scale_ram (
    .clk(clk), .we(sc_we), .waddr(sc_waddr), .wdata(sc_wdata),
    .raddr(sc_raddr), .rdata(sc_rdata));
  lups_ram #(.WIDTH(VW), .DEPTH(MAX_SIZE)) u_piv_ram (
    .clk(clk), .we(piv_we), .waddr(piv_waddr), .wdata(piv_wdata),
    .raddr(piv_raddr), .rdata(piv_rdata));

  lups_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p));
  lups_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .a(div_a), .b(div_b),
    .done(div_done), .q(div_q));

  always_comb begin
    if (ms_r == '0) n_clamp = CW'(1);
    else if (32'(ms_r) > MAX_SIZE) n_clamp = CW'(MAX_SIZE);
    else n_clamp = CW'(ms_r);
    kl     = (i_r < j_r) ? i_r : j_r;
    last_i = (i_r == n_r - CW'(1));
    last_j = (j_r == n_r - CW'(1));
    t_abs  = q_abs($signed(coef_rdata));
    pv     = (lu_rdata == 64'd0) ? Q_LSB : $signed(lu_rdata);
    ipv    = (CW'(piv_rdata) < n_r) ? CW'(piv_rdata) : i_r;
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    first_nxt     = first_r;
    ip_nxt        = ip_r;
    imax_nxt      = imax_r;
    started_nxt   = started_r;
    sum_nxt       = sum_r;
    a_nxt         = a_r;
    big_nxt       = big_r;
    tmp_nxt       = tmp_r;
    dum_nxt       = dum_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    coef_we    = 1'b0;
    coef_waddr = AW'(32'(in_req.row) * MAX_SIZE + 32'(in_req.column));
    coef_raddr = ea(i_r, j_r);
    lu_we      = 1'b0;
    lu_waddr   = ea(i_r, j_r);
    lu_wdata   = sum_r;
    lu_raddr   = ea(i_r, j_r);
    rhs_we     = 1'b0;
    rhs_waddr  = VW'(i_r);
    rhs_wdata  = sum_r;
    rhs_raddr  = VW'(i_r);
    sc_we      = 1'b0;
    sc_waddr   = VW'(i_r);
    sc_wdata   = div_q;
    sc_raddr   = VW'(i_r);
    piv_we     = 1'b0;
    piv_waddr  = VW'(j_r);
    piv_wdata  = VW'(imax_r);
    piv_raddr  = VW'(i_r);
    mul_start  = 1'b0;
    mul_a      = a_r;
    mul_b      = $signed(lu_rdata);
    div_start  = 1'b0;
    div_a      = Q_ONE;
    div_b      = big_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (cmd_t'(in_req.command))
            CMD_LOAD_A: begin
              coef_we = (32'(in_req.row) < MAX_SIZE) && (32'(in_req.column) < MAX_SIZE);
            end
            CMD_LOAD_B: begin
              rhs_we    = 32'(in_req.row) < MAX_SIZE;
              rhs_waddr = VW'(in_req.row);
              rhs_wdata = in_req.value;
            end
            CMD_SOLVE: begin
              n_nxt     = n_clamp;
              i_nxt     = '0;
              j_nxt     = '0;
              big_nxt   = '0;
              state_nxt = S_SC_RD;
            end
            default: ;
          endcase
        end
      end
      S_SC_RD: state_nxt = S_SC_WR;
      S_SC_WR: begin
        lu_we    = 1'b1;
        lu_wdata = coef_rdata;
        if (t_abs > big_r) big_nxt = t_abs;
        if (last_j) state_nxt = S_SC_CHK;
        else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_SC_RD;
        end
      end
      S_SC_CHK: begin
        if (big_r == '0) begin
          out_nxt       = '{element_index: '0, solution_value: '0, status: 1'b1, last: 1'b1};
          out_valid_nxt = 1'b1;
          state_nxt     = S_EM_WT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_SC_DIV;
        end
      end
      S_SC_DIV: begin
        if (div_done) begin
          sc_we    = 1'b1;
          j_nxt    = '0;
          big_nxt  = '0;
          imax_nxt = '0;
          if (last_i) begin
            i_nxt     = '0;
            state_nxt = S_CR_ST;
          end else begin
            i_nxt     = i_r + CW'(1);
            state_nxt = S_SC_RD;
          end
        end
      end
      S_CR_ST: begin
        k_nxt     = '0;
        state_nxt = S_CR_SUM;
      end
      S_CR_SUM: begin
        sum_nxt   = $signed(lu_rdata);
        state_nxt = (k_r == kl) ? S_CR_WR : S_CR_RA;
      end
      S_CR_RA: begin
        lu_raddr  = ea(i_r, k_r);
        state_nxt = S_CR_RB;
      end
      S_CR_RB: begin
        a_nxt     = $signed(lu_rdata);
        lu_raddr  = ea(k_r, j_r);
        state_nxt = S_CR_MUL;
      end
      S_CR_MUL: begin
        mul_start = 1'b1;
        state_nxt = S_CR_MW;
      end
      S_CR_MW: begin
        if (mul_done) begin
          sum_nxt   = q_sub(sum_r, mul_p);
          k_nxt     = k_r + CW'(1);
          state_nxt = ((k_r + CW'(1)) == kl) ? S_CR_WR : S_CR_RA;
        end
      end
      S_CR_WR: begin
        lu_we = 1'b1;
        if (i_r < j_r) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_CR_ST;
        end else begin
          state_nxt = S_CR_SC;
        end
      end
      S_CR_SC: begin
        mul_start = 1'b1;
        mul_a     = $signed(sc_rdata);
        mul_b     = q_abs(sum_r);
        state_nxt = S_CR_SW;
      end
      S_CR_SW: begin
        if (mul_done) begin
          if (mul_p >= big_r) begin
            big_nxt  = mul_p;
            imax_nxt = i_r;
          end
          if (last_i) state_nxt = S_PV_CHK;
          else begin
            i_nxt     = i_r + CW'(1);
            state_nxt = S_CR_ST;
          end
        end
      end
      S_PV_CHK: begin
        piv_we    = 1'b1;
        sc_raddr  = VW'(j_r);
        k_nxt     = '0;
        state_nxt = S_PV_SC;
      end
      S_PV_SC: begin
        sc_we     = imax_r != j_r;
        sc_waddr  = VW'(imax_r);
        sc_wdata  = sc_rdata;
        state_nxt = (imax_r != j_r) ? S_SW_RA : S_ZP_RD;
      end
      S_SW_RA: begin
        lu_raddr  = ea(imax_r, k_r);
        state_nxt = S_SW_RB;
      end
      S_SW_RB: begin
        tmp_nxt   = $signed(lu_rdata);
        lu_raddr  = ea(j_r, k_r);
        state_nxt = S_SW_W1;
      end
      S_SW_W1: begin
        lu_we     = 1'b1;
        lu_waddr  = ea(imax_r, k_r);
        lu_wdata  = lu_rdata;
        state_nxt = S_SW_W2;
      end
      S_SW_W2: begin
        lu_we    = 1'b1;
        lu_waddr = ea(j_r, k_r);
        lu_wdata = tmp_r;
        if (k_r == n_r - CW'(1)) state_nxt = S_ZP_RD;
        else begin
          k_nxt     = k_r + CW'(1);
          state_nxt = S_SW_RA;
        end
      end
      S_ZP_RD: begin
        lu_raddr  = ea(j_r, j_r);
        state_nxt = S_ZP_CHK;
      end
      S_ZP_CHK: begin
        lu_we    = lu_rdata == 64'd0;
        lu_waddr = ea(j_r, j_r);
        lu_wdata = Q_LSB;
        if (last_j) begin
          i_nxt       = '0;
          started_nxt = 1'b0;
          first_nxt   = '0;
          state_nxt   = S_FW_PV;
        end else begin
          div_start = 1'b1;
          div_b     = pv;
          state_nxt = S_ZP_DIV;
        end
      end
      S_ZP_DIV: begin
        if (div_done) begin
          dum_nxt   = div_q;
          i_nxt     = j_r + CW'(1);
          state_nxt = S_CS_RD;
        end
      end
      S_CS_RD: state_nxt = S_CS_MUL;
      S_CS_MUL: begin
        mul_start = 1'b1;
        mul_a     = $signed(lu_rdata);
        mul_b     = dum_r;
        state_nxt = S_CS_MW;
      end
      S_CS_MW: begin
        if (mul_done) begin
          lu_we    = 1'b1;
          lu_wdata = mul_p;
          if (last_i) begin
            j_nxt     = j_r + CW'(1);
            i_nxt     = '0;
            big_nxt   = '0;
            imax_nxt  = j_r + CW'(1);
            state_nxt = S_CR_ST;
          end else begin
            i_nxt     = i_r + CW'(1);
            state_nxt = S_CS_RD;
          end
        end
      end
      S_FW_PV: state_nxt = S_FW_IP;
      S_FW_IP: begin
        ip_nxt    = ipv;
        rhs_raddr = VW'(ipv);
        state_nxt = S_FW_RI;
      end
      S_FW_RI: begin
        sum_nxt   = $signed(rhs_rdata);
        state_nxt = S_FW_SW;
      end
      S_FW_SW: begin
        rhs_we    = 1'b1;
        rhs_waddr = VW'(ip_r);
        rhs_wdata = rhs_rdata;
        k_nxt     = first_r;
        if (started_r) begin
          state_nxt = (first_r < i_r) ? S_FW_RA : S_FW_WR;
        end else begin
          if (sum_r != '0) begin
            started_nxt = 1'b1;
            first_nxt   = i_r;
          end
          state_nxt = S_FW_WR;
        end
      end
      S_FW_RA: begin
        lu_raddr  = ea(i_r, k_r);
        rhs_raddr = VW'(k_r);
        state_nxt = S_FW_MUL;
      end
      S_FW_MUL: begin
        mul_start = 1'b1;
        mul_a     = $signed(lu_rdata);
        mul_b     = $signed(rhs_rdata);
        state_nxt = S_FW_MW;
      end
      S_FW_MW: begin
        if (mul_done) begin
          sum_nxt   = q_sub(sum_r, mul_p);
          k_nxt     = k_r + CW'(1);
          state_nxt = ((k_r + CW'(1)) == i_r) ? S_FW_WR : S_FW_RA;
        end
      end
      S_FW_WR: begin
        rhs_we = 1'b1;
        if (last_i) begin
          state_nxt = S_BK_RD;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_FW_PV;
        end
      end
      S_BK_RD: begin
        k_nxt     = i_r + CW'(1);
        state_nxt = S_BK_SUM;
      end
      S_BK_SUM: begin
        sum_nxt   = $signed(rhs_rdata);
        state_nxt = (k_r == n_r) ? S_BK_DR : S_BK_RA;
      end
      S_BK_RA: begin
        lu_raddr  = ea(i_r, k_r);
        rhs_raddr = VW'(k_r);
        state_nxt = S_BK_MUL;
      end
      S_BK_MUL: begin
        mul_start = 1'b1;
        mul_a     = $signed(lu_rdata);
        mul_b     = $signed(rhs_rdata);
        state_nxt = S_BK_MW;
      end
      S_BK_MW: begin
        if (mul_done) begin
          sum_nxt   = q_sub(sum_r, mul_p);
          k_nxt     = k_r + CW'(1);
          state_nxt = ((k_r + CW'(1)) == n_r) ? S_BK_DR : S_BK_RA;
        end
      end
      S_BK_DR: begin
        lu_raddr  = ea(i_r, i_r);
        state_nxt = S_BK_DIV;
      end
      S_BK_DIV: begin
        div_start = 1'b1;
        div_a     = sum_r;
        div_b     = pv;
        state_nxt = S_BK_DW;
      end
      S_BK_DW: begin
        if (div_done) begin
          rhs_we    = 1'b1;
          rhs_wdata = div_q;
          if (i_r == '0) begin
            state_nxt = S_EM_RD;
          end else begin
            i_nxt     = i_r - CW'(1);
            state_nxt = S_BK_RD;
          end
        end
      end
      S_EM_RD: state_nxt = S_EM_LD;
      S_EM_LD: begin
        out_nxt.element_index  = 4'(i_r);
        out_nxt.solution_value = $signed(rhs_rdata);
        out_nxt.status         = 1'b0;
        out_nxt.last           = last_i;
        out_valid_nxt          = 1'b1;
        state_nxt              = S_EM_WT;
      end
      S_EM_WT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_r.last) state_nxt = S_IDLE;
          else begin
            i_nxt     = i_r + CW'(1);
            state_nxt = S_EM_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ms_r        <= MS_W'(MS_RESET);
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      started_r   <= started_nxt;
      if (cfg_we) begin
        ms_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    first_r <= first_nxt;
    ip_r    <= ip_nxt;
    imax_r  <= imax_nxt;
    sum_r   <= sum_nxt;
    a_r     <= a_nxt;
    big_r   <= big_nxt;
    tmp_r   <= tmp_nxt;
    dum_r   <= dum_nxt;
    out_r   <= out_nxt;
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

// ----- tb/lu_pivot_linear_solver_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lu_pivot_linear_solver_test
// Self-checking bench for the pivoting LU solver. Requests are loaded, then
// solved under several system orders. Each accepted request updates a
// bit-accurate Q32.32 model of the solver, whose expected solution elements
// are checked in order against the result channel. Both channels idle in
// random bursts.
// ----------------------------------------------------------------------------
module lu_pivot_linear_solver_test;
  import lups_pkg::*;

  typedef logic signed [63:0] q_t;

  localparam int DIM = MAX_SIZE_DEF;
  localparam int WATCH_LIMIT = 200000;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  in_req_t         in_req = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_res_t        out_res;
  logic            cfg_we = 1'b0;
  logic [MS_W-1:0] cfg_wdata = '0;

  lu_pivot_linear_solver DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // model state
  q_t          coef_mem [DIM][DIM];
  q_t          rhs_mem [DIM];
  q_t          scale_mem [DIM];
  int          piv_mem [DIM];
  int unsigned sys_order = 16;
  out_res_t    solution_q [$];

  // stimulus state
  in_req_t     pend [$];
  bit          a_set [DIM][DIM];
  bit          b_set [DIM];
  int          gen_count = 0;
  int          big_count = 0;
  bit          calm = 1'b0;
  int          hold_asked = 0;
  int          errors = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] mag_of(input q_t v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic q_t sat_mag(input bit neg, input logic [63:0] mag, input bit ovf);
    if (neg) return (ovf || mag[63]) ? Q_MIN : q_t'(64'd0 - mag);
    return (ovf || mag[63]) ? Q_MAX : q_t'(mag);
  endfunction

  function automatic q_t fx_abs(input q_t v);
    return sat_mag(1'b0, mag_of(v), 1'b0);
  endfunction

  function automatic q_t fx_sub(input q_t a, input q_t b);
    logic [63:0] r;
    r = a - b;
    if ((a[63] != b[63]) && (r[63] != a[63])) return a[63] ? Q_MIN : Q_MAX;
    return q_t'(r);
  endfunction

  function automatic q_t fx_mul(input q_t a, input q_t b);
    logic [127:0] p;
    logic [63:0]  q;
    bit           ovf;
    bit           neg;
    neg = a[63] != b[63];
    p = {64'd0, mag_of(a)} * {64'd0, mag_of(b)};
    q = p[95:32];
    ovf = |p[127:96];
    if (neg && |p[31:0]) begin
      q = q + 64'd1;
      if (q == 64'd0) ovf = 1'b1;
    end
    return sat_mag(neg, q, ovf);
  endfunction

  function automatic q_t fx_div(input q_t a, input q_t b);
    logic [63:0] ub;
    logic [95:0] quo;
    ub = mag_of(b);
    if (ub == 64'd0) return a[63] ? Q_MIN : Q_MAX;
    quo = {mag_of(a), 32'd0} / {32'd0, ub};
    return sat_mag(a[63] != b[63], quo[63:0], |quo[95:64]);
  endfunction

  function automatic void solve_system();
    q_t       lu [DIM][DIM];
    q_t       w [DIM];
    q_t       big, sum, dum, t;
    int       n, imax, first, ip;
    bit       started;
    out_res_t r;
    n = (sys_order < 1) ? 1 : (sys_order > DIM) ? DIM : sys_order;
    started = 1'b0;
    first = 0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) lu[i][j] = coef_mem[i][j];
    for (int i = 0; i < n; i++) begin
      big = 0;
      for (int j = 0; j < n; j++) begin
        t = fx_abs(lu[i][j]);
        if (t > big) big = t;
      end
      if (big == 0) begin
        r.element_index = 4'd0;
        r.solution_value = 64'sd0;
        r.status = 1'b1;
        r.last = 1'b1;
        solution_q.push_back(r);
        return;
      end
      scale_mem[i] = fx_div(Q_ONE, big);
    end
    for (int j = 0; j < n; j++) begin
      for (int i = 0; i < j; i++) begin
        sum = lu[i][j];
        for (int k = 0; k < i; k++) sum = fx_sub(sum, fx_mul(lu[i][k], lu[k][j]));
        lu[i][j] = sum;
      end
      big = 0;
      imax = j;
      for (int i = j; i < n; i++) begin
        sum = lu[i][j];
        for (int k = 0; k < j; k++) sum = fx_sub(sum, fx_mul(lu[i][k], lu[k][j]));
        lu[i][j] = sum;
        dum = fx_mul(scale_mem[i], fx_abs(sum));
        if (dum >= big) begin
          big = dum;
          imax = i;
        end
      end
      if (imax != j) begin
        for (int k = 0; k < n; k++) begin
          dum = lu[imax][k];
          lu[imax][k] = lu[j][k];
          lu[j][k] = dum;
        end
        scale_mem[imax] = scale_mem[j];
      end
      piv_mem[j] = imax;
      if (lu[j][j] == 0) lu[j][j] = Q_LSB;
      if (j != n - 1) begin
        dum = fx_div(Q_ONE, lu[j][j]);
        for (int i = j + 1; i < n; i++) lu[i][j] = fx_mul(lu[i][j], dum);
      end
    end
    for (int i = 0; i < n; i++) w[i] = rhs_mem[i];
    for (int i = 0; i < n; i++) begin
      ip = (piv_mem[i] < n) ? piv_mem[i] : i;
      sum = w[ip];
      w[ip] = w[i];
      if (started) begin
        for (int j = first; j < i; j++) sum = fx_sub(sum, fx_mul(lu[i][j], w[j]));
      end else if (sum != 0) begin
        started = 1'b1;
        first = i;
      end
      w[i] = sum;
    end
    for (int i = n - 1; i >= 0; i--) begin
      sum = w[i];
      for (int j = i + 1; j < n; j++) sum = fx_sub(sum, fx_mul(lu[i][j], w[j]));
      w[i] = fx_div(sum, (lu[i][i] != 0) ? lu[i][i] : Q_LSB);
    end
    for (int i = 0; i < n; i++) begin
      rhs_mem[i] = w[i];
      r.element_index = 4'(i);
      r.solution_value = w[i];
      r.status = 1'b0;
      r.last = (i == n - 1);
      solution_q.push_back(r);
    end
  endfunction

  function automatic void apply_request(input in_req_t req);
    case (cmd_t'(req.command))
      CMD_LOAD_A: coef_mem[req.row][req.column] = req.value;
      CMD_LOAD_B: rhs_mem[req.row] = req.value;
      CMD_SOLVE:  solve_system();
      default: ;
    endcase
  endfunction

  // driver
  int gap_left = 0;
  always @(posedge clk) begin
    bit busy;
    bit nv;
    busy = 1'b0;
    nv = 1'b0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_request(in_req);
      else busy = in_valid;
      if (busy) begin
        nv = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pend.size() > 0) begin
        nv = 1'b1;
        in_req <= pend.pop_front();
        if (!calm && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 19);
      end
      in_valid <= nv;
    end
  end

  // monitor
  int stall_left = 0;
  int hold_cnt = 0;
  int hold_done = 0;
  always @(posedge clk) begin
    out_res_t exp_r;
    bit nr;
    nr = 1'b0;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (solution_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none, actual %p", $time, out_res);
        end else begin
          exp_r = solution_q.pop_front();
          if (out_res.element_index !== exp_r.element_index) begin
            errors++;
            $display("%0t element_index: expected %0d, actual %0d", $time,
                     exp_r.element_index, out_res.element_index);
          end
          if (out_res.solution_value !== exp_r.solution_value) begin
            errors++;
            $display("%0t solution_value: expected %h, actual %h", $time,
                     exp_r.solution_value, out_res.solution_value);
          end
          if (out_res.status !== exp_r.status) begin
            errors++;
            $display("%0t status: expected %0d, actual %0d", $time,
                     exp_r.status, out_res.status);
          end
          if (out_res.last !== exp_r.last) begin
            errors++;
            $display("%0t last: expected %0d, actual %0d", $time,
                     exp_r.last, out_res.last);
          end
        end
      end
      if (hold_asked != hold_done) begin
        hold_done = hold_asked;
        hold_cnt = 40000;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 18);
      end else begin
        nr = 1'b1;
      end
      out_ready <= nr;
    end
  end

  // watchdog
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (pend.size() == 0 && !in_valid && solution_q.size() == 0)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCH_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic q_t rnd_val();
    case ($urandom_range(0, 9))
      0:       return 64'sd0;
      1:       return Q_MAX;
      2:       return Q_MIN;
      3:       return q_t'({$urandom, $urandom});
      4, 5:    return q_t'($signed($urandom_range(0, 16)) - 8) <<< 32;
      default: return q_t'($signed({{28{1'b0}}, $urandom_range(0, 32'hFFFFFFF)}) - 32'sh8000000)
                      <<< $urandom_range(4, 12);
    endcase
  endfunction

  task automatic put(input cmd_t cmd, input int r, input int c, input q_t v);
    in_req_t req;
    req.command = cmd;
    req.row = 4'(r);
    req.column = 4'(c);
    req.value = v;
    pend.push_back(req);
    if (cmd == CMD_LOAD_A) a_set[r][c] = 1'b1;
    if (cmd == CMD_LOAD_B) b_set[r] = 1'b1;
    if (cmd != CMD_NONE) gen_count++;
  endtask

  task automatic drain();
    @(negedge clk);
    while (pend.size() != 0 || in_valid || solution_q.size() != 0) @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_size(input int unsigned v);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[4:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sys_order = v[4:0];
  endtask

  task automatic noise();
    case ($urandom_range(0, 2))
      0: put(CMD_NONE, $urandom_range(0, 15), $urandom_range(0, 15), rnd_val());
      1: put(CMD_LOAD_A, $urandom_range(0, 15), $urandom_range(0, 15), rnd_val());
      default: put(CMD_LOAD_B, $urandom_range(0, 15), 0, rnd_val());
    endcase
  endtask

  task automatic ensure_loaded(input int n);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++)
        if (!a_set[i][j]) put(CMD_LOAD_A, i, j, rnd_val());
      if (!b_set[i]) put(CMD_LOAD_B, i, $urandom_range(0, 15), rnd_val());
    end
  endtask

  task automatic fill_system(input int n);
    if (n <= 6) begin
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          put(CMD_LOAD_A, i, j, rnd_val());
          if ($urandom_range(0, 9) == 0) noise();
        end
    end else begin
      for (int k = 0; k < 8; k++)
        put(CMD_LOAD_A, $urandom_range(0, n - 1), $urandom_range(0, n - 1), rnd_val());
    end
    for (int i = 0; i < n; i++) put(CMD_LOAD_B, i, $urandom_range(0, 15), rnd_val());
  endtask

  initial begin
    int v, n, zr, src;
    q_t f;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // ties, zero pivot and extreme right-hand side
    set_size(2);
    hold_asked++;
    put(CMD_LOAD_A, 0, 0, Q_ONE);
    put(CMD_LOAD_A, 0, 1, Q_ONE);
    put(CMD_LOAD_A, 1, 0, Q_ONE);
    put(CMD_LOAD_A, 1, 1, Q_ONE);
    put(CMD_LOAD_B, 0, 15, Q_MAX);
    put(CMD_LOAD_B, 1, 0, Q_MIN);
    put(CMD_SOLVE, 0, 0, 64'sd0);
    put(CMD_NONE, 15, 15, Q_MIN);
    put(CMD_LOAD_A, 15, 15, Q_MIN);
    put(CMD_LOAD_B, 15, 0, Q_MAX);
    put(CMD_SOLVE, 15, 15, Q_MAX);
    // order 0 acts as 1: zero row, then most negative entry
    set_size(0);
    put(CMD_LOAD_A, 0, 0, 64'sd0);
    put(CMD_SOLVE, 0, 0, 64'sd0);
    put(CMD_LOAD_A, 0, 0, Q_MIN);
    put(CMD_SOLVE, 0, 0, 64'sd0);

    while (gen_count < 350) begin
      v = $urandom_range(0, 19);
      if (v == 0) v = 0;
      else if ((v == 1 || big_count == 0) && big_count < 3 && gen_count > 80) begin
        v = (big_count == 0) ? 16 : (big_count == 1) ? 31 : $urandom_range(17, 30);
        big_count++;
      end else v = $urandom_range(2, 6);
      set_size(v);
      n = (v < 1) ? 1 : (v > DIM) ? DIM : v;
      if (gen_count > 300) calm = 1'b1;
      ensure_loaded(n);
      for (int s = $urandom_range(1, 3); s > 0; s--) begin
        case ($urandom_range(0, 9))
          6: begin
            zr = $urandom_range(0, n - 1);
            for (int j = 0; j < n; j++) put(CMD_LOAD_A, zr, j, 64'sd0);
          end
          7: ;
          8: for (int k = $urandom_range(1, 4); k > 0; k--) noise();
          9: begin
            fill_system(n);
            if (n > 1) begin
              src = $urandom_range(0, n - 1);
              zr = (src + 1) % n;
              f = rnd_val();
              for (int j = 0; j < n; j++) put(CMD_LOAD_A, src, j, f);
              for (int j = 0; j < n; j++) put(CMD_LOAD_A, zr, j, f);
            end
          end
          default: fill_system(n);
        endcase
        put(CMD_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15), rnd_val());
      end
      ensure_loaded(n);
    end

    drain();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
